FILE: hw/rtl/vau_pkg.sv
// ----------------------------------------------------------------------------
// vau_pkg
// Types, mode codes and pipeline sizes shared by the vector arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vau_pkg;

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_SCL  = 3'd2;
    localparam logic [2:0] MODE_DOT  = 3'd3;
    localparam logic [2:0] MODE_MAG  = 3'd4;
    localparam logic [2:0] MODE_NORM = 3'd5;

    // one root bit per stage, one quotient bit per stage
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] factor;
    } req_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [63:0] scalar;
        logic               error;
    } res_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [63:0] scalar;
    } ctx_t;

    typedef struct packed {
        logic        valid;
        ctx_t        ctx;
        logic [63:0] v;
        logic [35:0] rem;
        logic [31:0] root;
    } sq_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [16:0] dvd;
        logic [16:0] quo;
    } dl_t;

    typedef struct packed {
        logic        valid;
        ctx_t        ctx;
        logic [31:0] mag;
        dl_t         lx;
        dl_t         ly;
    } dv_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vector2_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// vector2_arithmetic_unit
// Pipelined Q16.16 2D vector add, subtract, scale, dot, magnitude, normalize.
// ----------------------------------------------------------------------------
// Takes one request per cycle while not stalled and returns one result per
// request, in order, through two stages of multiply and sum, 32 square root
// stages (one root bit each), 17 divide stages (one quotient bit each, both
// components in parallel) and an output register. Every mode travels the
// full pipeline. A stall on the result side holds the whole pipeline and
// is passed straight back as a stall on the request side.
`default_nettype none

module vector2_arithmetic_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire vau_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_stall,
    output vau_pkg::res_t      res
);

    logic          en;
    logic          res_valid_reg;
    vau_pkg::res_t res_reg;
    vau_pkg::res_t res_next;

    vau_pkg::sq_t  sq [vau_pkg::SQRT_STEPS+1];
    vau_pkg::dv_t  dv [vau_pkg::DIV_STEPS+1];

    assign en        = !(res_valid_reg && res_stall);
    assign req_stall = !en;

    vau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (req_valid),
        .req      (req),
        .q        (sq[0])
    );

    for (genvar i = 0; i < vau_pkg::SQRT_STEPS; i++)
    begin : g_sqrt
        vau_sqrt_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (sq[i]),
            .q     (sq[i+1])
        );
    end

    // divide set-up: |a| << 16 with the top bits preloaded as remainder
    always_comb
    begin
        logic [31:0] mx;
        logic [31:0] my;
        mx = sq[vau_pkg::SQRT_STEPS].ctx.a_x[31] ?
             (32'd0 - sq[vau_pkg::SQRT_STEPS].ctx.a_x) : sq[vau_pkg::SQRT_STEPS].ctx.a_x;
        my = sq[vau_pkg::SQRT_STEPS].ctx.a_y[31] ?
             (32'd0 - sq[vau_pkg::SQRT_STEPS].ctx.a_y) : sq[vau_pkg::SQRT_STEPS].ctx.a_y;
        dv[0].valid  = sq[vau_pkg::SQRT_STEPS].valid;
        dv[0].ctx    = sq[vau_pkg::SQRT_STEPS].ctx;
        dv[0].mag    = sq[vau_pkg::SQRT_STEPS].root;
        dv[0].lx.rem = {1'b0, mx[31:1]};
        dv[0].lx.dvd = {mx[0], 16'd0};
        dv[0].lx.quo = '0;
        dv[0].ly.rem = {1'b0, my[31:1]};
        dv[0].ly.dvd = {my[0], 16'd0};
        dv[0].ly.quo = '0;
    end

    for (genvar i = 0; i < vau_pkg::DIV_STEPS; i++)
    begin : g_div
        vau_div_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (dv[i]),
            .q     (dv[i+1])
        );
    end

    always_comb
    begin
        vau_pkg::dv_t t;
        t                 = dv[vau_pkg::DIV_STEPS];
        res_next.r_x      = t.ctx.r_x;
        res_next.r_y      = t.ctx.r_y;
        res_next.scalar   = t.ctx.scalar;
        res_next.error    = 1'b0;
        case (t.ctx.mode)
            vau_pkg::MODE_MAG:
                res_next.scalar = {32'd0, t.mag};
            vau_pkg::MODE_NORM:
            begin
                if (t.mag == '0)
                begin
                    res_next.error = 1'b1;
                    res_next.r_x   = '0;
                    res_next.r_y   = '0;
                end
                else
                begin
                    res_next.r_x = t.ctx.a_x[31] ? (32'd0 - {15'd0, t.lx.quo})
                                                 : {15'd0, t.lx.quo};
                    res_next.r_y = t.ctx.a_y[31] ? (32'd0 - {15'd0, t.ly.quo})
                                                 : {15'd0, t.ly.quo};
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= dv[vau_pkg::DIV_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/vau_front.sv
// ----------------------------------------------------------------------------
// vau_front
// Two stages: products and saturated sums, then mode results and A.A.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire vau_pkg::req_t req,
    output vau_pkg::sq_t       q
);

    function automatic logic signed [31:0] sat_sum(input logic signed [32:0] s);
        logic signed [31:0] r;
        if (s[32] != s[31])
            r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            r = s[31:0];
        return r;
    endfunction

    // round half away from zero, then saturate
    function automatic logic signed [31:0] sat_scale(input logic signed [63:0] p);
        logic [63:0]        m;
        logic [63:0]        rnd;
        logic [47:0]        qv;
        logic signed [31:0] r;
        m   = p[63] ? (64'd0 - p) : p;
        rnd = m + 64'h8000;
        qv  = rnd[63:16];
        if (p[63])
            r = (qv > 48'h8000_0000) ? 32'sh8000_0000 : (32'sd0 - qv[31:0]);
        else
            r = (qv > 48'h7fff_ffff) ? 32'sh7fff_ffff : qv[31:0];
        return r;
    endfunction

    logic               s1_valid_reg;
    logic [2:0]         s1_mode_reg;
    logic signed [31:0] s1_ax_reg, s1_ay_reg;
    logic signed [31:0] s1_add_x_reg, s1_add_y_reg, s1_sub_x_reg, s1_sub_y_reg;
    logic signed [63:0] s1_pxx_reg, s1_pyy_reg, s1_pxb_reg, s1_pyb_reg;
    logic signed [63:0] s1_pxf_reg, s1_pyf_reg;

    logic               s2_valid_reg;
    vau_pkg::sq_t       s2_reg;
    vau_pkg::sq_t       s2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mode_reg  <= req.mode;
            s1_ax_reg    <= req.a_x;
            s1_ay_reg    <= req.a_y;
            s1_add_x_reg <= sat_sum(33'(req.a_x) + 33'(req.b_x));
            s1_add_y_reg <= sat_sum(33'(req.a_y) + 33'(req.b_y));
            s1_sub_x_reg <= sat_sum(33'(req.a_x) - 33'(req.b_x));
            s1_sub_y_reg <= sat_sum(33'(req.a_y) - 33'(req.b_y));
            s1_pxx_reg   <= 64'(req.a_x) * 64'(req.a_x);
            s1_pyy_reg   <= 64'(req.a_y) * 64'(req.a_y);
            s1_pxb_reg   <= 64'(req.a_x) * 64'(req.b_x);
            s1_pyb_reg   <= 64'(req.a_y) * 64'(req.b_y);
            s1_pxf_reg   <= 64'(req.a_x) * 64'(req.factor);
            s1_pyf_reg   <= 64'(req.a_y) * 64'(req.factor);
            s2_reg       <= s2_next;
        end
    end

    always_comb
    begin
        logic [63:0] dot;
        dot = s1_pxb_reg + s1_pyb_reg;
        // only two non-negative products can overflow
        if (!s1_pxb_reg[63] && !s1_pyb_reg[63] && dot[63])
            dot = 64'h7fff_ffff_ffff_ffff;

        s2_next            = '0;
        s2_next.ctx.mode   = s1_mode_reg;
        s2_next.ctx.a_x    = s1_ax_reg;
        s2_next.ctx.a_y    = s1_ay_reg;
        s2_next.v          = s1_pxx_reg + s1_pyy_reg;
        case (s1_mode_reg)
            vau_pkg::MODE_ADD:
            begin
                s2_next.ctx.r_x = s1_add_x_reg;
                s2_next.ctx.r_y = s1_add_y_reg;
            end
            vau_pkg::MODE_SUB:
            begin
                s2_next.ctx.r_x = s1_sub_x_reg;
                s2_next.ctx.r_y = s1_sub_y_reg;
            end
            vau_pkg::MODE_SCL:
            begin
                s2_next.ctx.r_x = sat_scale(s1_pxf_reg);
                s2_next.ctx.r_y = sat_scale(s1_pyf_reg);
            end
            vau_pkg::MODE_DOT:
                s2_next.ctx.scalar = dot;
            default:
                ;
        endcase
    end

    always_comb
    begin
        q       = s2_reg;
        q.valid = s2_valid_reg;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/vau_sqrt_step.sv
// ----------------------------------------------------------------------------
// vau_sqrt_step
// One registered step of the restoring square root: one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_sqrt_step (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire vau_pkg::sq_t d,
    output vau_pkg::sq_t      q
);

    logic         valid_reg;
    vau_pkg::sq_t data_reg;
    vau_pkg::sq_t data_next;

    always_comb
    begin
        logic [35:0] rem_sh;
        logic [35:0] trial;
        rem_sh    = {d.rem[33:0], d.v[63:62]};
        trial     = {2'b00, d.root, 2'b01};
        data_next = d;
        data_next.v = {d.v[61:0], 2'b00};
        if (rem_sh >= trial)
        begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {d.root[30:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh;
            data_next.root = {d.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/vau_div_step.sv
// ----------------------------------------------------------------------------
// vau_div_step
// One registered step of two restoring divide lanes: one quotient bit each.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_div_step (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire vau_pkg::dv_t d,
    output vau_pkg::dv_t      q
);

    function automatic vau_pkg::dl_t lane(input vau_pkg::dl_t l, input logic [31:0] m);
        logic [32:0]  sh;
        logic [32:0]  diff;
        vau_pkg::dl_t r;
        sh    = {l.rem, l.dvd[16]};
        diff  = sh - {1'b0, m};
        r.dvd = {l.dvd[15:0], 1'b0};
        if (!diff[32])
        begin
            r.rem = diff[31:0];
            r.quo = {l.quo[15:0], 1'b1};
        end
        else
        begin
            r.rem = sh[31:0];
            r.quo = {l.quo[15:0], 1'b0};
        end
        return r;
    endfunction

    logic         valid_reg;
    vau_pkg::dv_t data_reg;
    vau_pkg::dv_t data_next;

    always_comb
    begin
        data_next    = d;
        data_next.lx = lane(d.lx, d.mag);
        data_next.ly = lane(d.ly, d.mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/vau_checker.sv
// ----------------------------------------------------------------------------
// vau_checker
// Port-level checks on the vector arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_stall,
    input wire logic          res_valid,
    input wire logic          res_stall,
    input wire vau_pkg::res_t res
);

    // a held result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // request side stalls exactly when a result is held back
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (res_valid && res_stall))
        else $error("request stall does not follow result stall");

    // error result carries only zeros
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.error |-> res.r_x == '0 && res.r_y == '0 && res.scalar == '0)
        else $error("error result with nonzero fields");

    // negative scalar only comes from dot, which has no vector part
    a_neg_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.scalar[63] |-> res.r_x == '0 && res.r_y == '0 && !res.error)
        else $error("negative scalar with vector part");

endmodule

bind vector2_arithmetic_unit vau_checker u_vau_checker (.*);

`default_nettype wire
